FILE: src/ple_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the positional list engine.
// No dependencies; used by every module under src.
package ple_pkg;

    localparam int PLE_CAPACITY = 32;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 8;
    localparam int COUNT_OUT_W  = 6;

    typedef enum logic [2:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_INS_POS   = 3'd2,
        MODE_DEL_FRONT = 3'd3,
        MODE_DEL_BACK  = 3'd4,
        MODE_DEL_POS   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD   = 2'd0,
        SHIFT_INSERT = 2'd1,
        SHIFT_DELETE = 2'd2
    } shift_op_t;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        shift_op_t        op;
        logic [POS_W-1:0] idx;
    } shift_ctrl_t;

    typedef struct packed {
        logic [2:0]                mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [COUNT_OUT_W-1:0] element_count;
    } out_item_t;

endpackage

FILE: src/ple_cell.sv
`timescale 1ns / 1ps
// One storage cell of the positional list chain.
// Depends on ple_pkg for the shift command type.
module ple_cell
    import ple_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic                      aclk,
    input  shift_ctrl_t               ctrl,
    input  logic signed [VALUE_W-1:0] ins_value,
    input  logic signed [VALUE_W-1:0] prev_data,
    input  logic signed [VALUE_W-1:0] next_data,
    output logic signed [VALUE_W-1:0] data_q
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(CELL_INDEX);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            SHIFT_INSERT: begin
                if (MY_IDX == ctrl.idx) begin
                    data_next = ins_value;
                end else if (MY_IDX > ctrl.idx) begin
                    data_next = prev_data;
                end
            end
            SHIFT_DELETE: begin
                // close the gap: take from the back neighbor
                if (MY_IDX >= ctrl.idx) begin
                    data_next = next_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

FILE: src/ple_ctrl.sv
`timescale 1ns / 1ps
// Request decode for the positional list: position checks, status,
// next element count and the shift command for the cell chain. Uses ple_pkg.
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = PLE_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic             fire,
    input  in_item_t         req,
    input  logic [CNT_W-1:0] count,
    output shift_ctrl_t      ctrl,
    output status_t          status,
    output logic [CNT_W-1:0] count_next
);

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [POS_W:0] cnt_ext;
    logic [POS_W:0] pos_ext;
    logic           pos_ok_ins;
    logic           pos_ok_del;
    logic           full;
    logic           empty;
    shift_op_t      op;
    logic [POS_W-1:0] idx;

    always_comb begin
        cnt_ext    = (POS_W + 1)'(count);
        pos_ext    = {1'b0, req.position};
        pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);
        pos_ok_del = (pos_ext != '0) && (pos_ext <= cnt_ext);
        full       = (count == CAP_C);
        empty      = (count == '0);
    end

    always_comb begin
        op     = SHIFT_HOLD;
        idx    = '0;
        status = ST_DONE;
        case (req.mode)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
                if (req.mode == MODE_INS_BACK) begin
                    idx = POS_W'(count);
                end else if (req.mode == MODE_INS_POS) begin
                    idx = req.position - 1'b1;
                end
                if (req.mode == MODE_INS_POS && !pos_ok_ins) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    op = SHIFT_INSERT;
                end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
                if (req.mode == MODE_DEL_BACK) begin
                    idx = POS_W'(count) - 1'b1;
                end else if (req.mode == MODE_DEL_POS) begin
                    idx = req.position - 1'b1;
                end
                if (empty) begin
                    status = ST_EMPTY;
                end else if (req.mode == MODE_DEL_POS && !pos_ok_del) begin
                    status = ST_BADPOS;
                end else begin
                    op = SHIFT_DELETE;
                end
            end
            default: status = ST_BADPOS;
        endcase
    end

    always_comb begin
        ctrl.op  = fire ? op : SHIFT_HOLD;
        ctrl.idx = idx;
        case (op)
            SHIFT_INSERT: count_next = count + 1'b1;
            SHIFT_DELETE: count_next = count - 1'b1;
            default:      count_next = count;
        endcase
    end

endmodule

FILE: src/positional_list_engine_core.sv
`timescale 1ns / 1ps
// Positional list engine: an ordered list of signed 32-bit values kept in a
// shifting chain of CAPACITY cells. Uses ple_pkg, ple_ctrl and ple_cell.
//
// Usage:
//   Requests arrive on s_valid/s_ready/s_payload with a mode (insert front,
//   insert back, insert at position, delete front, delete back, delete at
//   position), a value and a 1-based position. Each request gives exactly
//   one result on m_valid/m_ready/m_payload: a status (done, invalid
//   position, list full, list empty) and the element count afterward.
//   The result is registered at the edge that accepts the request; throughput
//   is one request per cycle unless the receiver stalls, since every cell
//   loads its new entry from itself, its front neighbor, its back neighbor or
//   the request value in the same cycle.
//   A held result register parts the two sides: a new request is taken
//   while the result is taken in the same cycle; while the receiver stalls
//   s_ready stays low and the result holds.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result. Cell contents are undefined until written and never observed.
module positional_list_engine_core
    import ple_pkg::*;
#(
    parameter int CAPACITY = PLE_CAPACITY
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        result_reg;
    out_item_t        result_next;

    logic        fire;
    shift_ctrl_t ctrl;
    status_t     status;
    logic [CNT_W-1:0] ctrl_count;

    logic signed [VALUE_W-1:0] cell_q [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .fire       (fire),
        .req        (s_payload),
        .count      (count_reg),
        .ctrl       (ctrl),
        .status     (status),
        .count_next (ctrl_count)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] prev_d;
        logic signed [VALUE_W-1:0] next_d;

        if (i == 0) begin : g_first
            assign prev_d = s_payload.value;
        end else begin : g_mid_prev
            assign prev_d = cell_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_d = cell_q[i];
        end else begin : g_mid_next
            assign next_d = cell_q[i+1];
        end

        ple_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .ins_value (s_payload.value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data_q    (cell_q[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        result_next  = result_reg;
        if (fire) begin
            count_next                = ctrl_count;
            m_valid_next              = 1'b1;
            result_next.status        = status;
            result_next.element_count = COUNT_OUT_W'(ctrl_count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = result_reg;

endmodule
